FILE: hdl/sts_pkg.sv
// Package for the spline tangent smoother: job descriptor type and fixed constants.
// No dependencies.
package sts_pkg;

    localparam int TENSION_BITS = 16;
    localparam logic [15:0] TENSION_RESET = 16'd11010;

    // Register indexes of the configuration port.
    localparam logic REG_CLOSED_LOOP = 1'b0;
    localparam logic REG_TENSION = 1'b1;

    // Wide working widths: coordinates up to 32 bits, differences 33,
    // squares 66, sums of squares 67, roots 34, distance sums 35.
    localparam int DW = 34;          // difference magnitude width
    localparam int SW = 68;          // sum of squares width
    localparam int RW = 35;          // root width
    localparam int KW = 52;          // tension * distance sum
    localparam int NUMW = 88;        // k * |d| + half
    localparam int QW = 64;          // quotient width

    // One request for the back end: the three points and where the result goes.
    typedef struct packed {
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic [31:0] idx;
        logic zero;     // open end point: controls are (0, 0)
        logic last;
    } job_t;

endpackage

FILE: hdl/sts_front.sv
// Front end of the spline tangent smoother: tracks the list and issues jobs.
// Depends on sts_pkg.
module sts_front import sts_pkg::*; #(
    parameter int INDEX_BITS = 16,
    parameter int COORD_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         closed_loop,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_point_x,
    input  logic signed [COORD_BITS-1:0] s_point_y,
    input  logic                         s_last_point,
    output logic                         j_valid,
    input  logic                         j_ready,
    output job_t                         j_job
);

    localparam logic [INDEX_BITS-1:0] MAX_IDX = {INDEX_BITS{1'b1}};

    logic signed [31:0] older_x_reg, older_y_reg, newer_x_reg, newer_y_reg;
    logic signed [31:0] head_x_reg, head_y_reg, second_x_reg, second_y_reg;
    logic [INDEX_BITS-1:0] seen_reg;
    logic closed_reg;

    // Jobs of the point being issued, one per cycle while the queue takes them.
    job_t jobs_reg [3];
    logic [1:0] count_reg, pos_reg;
    logic busy_reg;

    logic signed [31:0] cx, cy;
    logic cl, first, second, last;
    job_t j0, j1, j2;
    logic [1:0] cnt;

    assign cx = 32'(s_point_x);
    assign cy = 32'(s_point_y);
    assign last = s_last_point;
    assign first = (seen_reg == '0);
    assign second = (seen_reg == INDEX_BITS'(1));
    assign cl = first ? closed_loop : closed_reg;
    assign s_ready = !busy_reg;

    // Build the list of results that this point causes.
    always_comb begin
        job_t jm, je, ja, jb;
        jm = '{qx: older_x_reg, qy: older_y_reg, px: newer_x_reg, py: newer_y_reg,
               rx: cx, ry: cy, idx: 32'(seen_reg - INDEX_BITS'(1)), zero: 1'b0,
               last: 1'b0};
        je = '{qx: 32'sd0, qy: 32'sd0, px: 32'sd0, py: 32'sd0, rx: 32'sd0, ry: 32'sd0,
               idx: 32'(seen_reg), zero: 1'b1, last: last};
        ja = '{qx: first ? cx : newer_x_reg, qy: first ? cy : newer_y_reg,
               px: cx, py: cy, rx: first ? cx : head_x_reg,
               ry: first ? cy : head_y_reg, idx: first ? 32'd0 : 32'(seen_reg),
               zero: 1'b0, last: first};
        jb = '{qx: cx, qy: cy, px: head_x_reg, py: head_y_reg,
               rx: second ? cx : second_x_reg, ry: second ? cy : second_y_reg,
               idx: 32'd0, zero: 1'b0, last: 1'b1};
        j0 = jm; j1 = jm; j2 = jm;
        cnt = 2'd0;
        if (!first && !second) begin
            j0 = jm;
            cnt = 2'd1;
        end
        if (!cl) begin
            if (first || last) begin
                if (cnt == 2'd0) j0 = je; else j1 = je;
                cnt = cnt + 2'd1;
            end
        end else if (last) begin
            if (first) begin
                j0 = ja;
                cnt = 2'd1;
            end else begin
                if (cnt == 2'd0) begin
                    j0 = ja; j1 = jb;
                end else begin
                    j1 = ja; j2 = jb;
                end
                cnt = cnt + 2'd2;
            end
        end
    end

    assign j_valid = busy_reg;
    assign j_job = jobs_reg[pos_reg];

    // List tracking on each accepted point.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            closed_reg <= 1'b0;
            busy_reg <= 1'b0;
            count_reg <= 2'd0;
            pos_reg <= 2'd0;
            older_x_reg <= '0; older_y_reg <= '0;
            newer_x_reg <= '0; newer_y_reg <= '0;
            head_x_reg <= '0; head_y_reg <= '0;
            second_x_reg <= '0; second_y_reg <= '0;
        end else if (s_valid && s_ready) begin
            if (first) begin
                closed_reg <= closed_loop;
                head_x_reg <= cx;
                head_y_reg <= cy;
            end else if (second) begin
                second_x_reg <= cx;
                second_y_reg <= cy;
            end
            older_x_reg <= newer_x_reg;
            older_y_reg <= newer_y_reg;
            newer_x_reg <= cx;
            newer_y_reg <= cy;
            if (last) seen_reg <= '0;
            else if (seen_reg != MAX_IDX) seen_reg <= seen_reg + INDEX_BITS'(1);
            jobs_reg[0] <= j0;
            jobs_reg[1] <= j1;
            jobs_reg[2] <= j2;
            count_reg <= cnt;
            pos_reg <= 2'd0;
            busy_reg <= (cnt != 2'd0);
        end else if (busy_reg && j_ready) begin
            pos_reg <= pos_reg + 2'd1;
            if (pos_reg + 2'd1 == count_reg) busy_reg <= 1'b0;
        end
    end

    // A job is only offered for an occupied slot.
    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> pos_reg < count_reg) else $error("job slot out of range");
    a_nobusy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_ready) else $error("point taken while issuing");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> count_reg != 2'd0) else $error("empty job list issued");

endmodule

FILE: hdl/sts_queue.sv
// Two-entry job queue between front and back end of the smoother.
// Depends on sts_pkg.
module sts_queue import sts_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] fill_reg;

    assign in_ready = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_job = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) mem_reg[wp_reg] <= in_job;
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            if (in_valid && in_ready) wp_reg <= !wp_reg;
            if (out_valid && out_ready) rp_reg <= !rp_reg;
            fill_reg <= fill_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
        end
    end

endmodule

FILE: hdl/sts_back.sv
// Back end of the smoother: distances, scaling division and saturation.
// Square root and restoring division are separate bit-serial steps, one bit per cycle.
// Depends on sts_pkg.
module sts_back import sts_pkg::*; #(
    parameter int INDEX_BITS = 16,
    parameter int COORD_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [TENSION_BITS-1:0]      tension,
    input  logic                         j_valid,
    output logic                         j_ready,
    input  job_t                         j_job,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [INDEX_BITS-1:0]        m_point_index,
    output logic signed [COORD_BITS-1:0] m_ctrl_a_x,
    output logic signed [COORD_BITS-1:0] m_ctrl_a_y,
    output logic signed [COORD_BITS-1:0] m_ctrl_b_x,
    output logic signed [COORD_BITS-1:0] m_ctrl_b_y,
    output logic                         m_last_result
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_SQ2 = 4'd2, S_ROOT = 4'd3,
                           S_NEXT = 4'd4, S_K = 4'd5, S_NUM = 4'd6, S_DIV = 4'd7,
                           S_OUT = 4'd8, S_MUL = 4'd9;
    localparam logic signed [36:0] CMAX = 37'sd1 <<< (COORD_BITS - 1);
    localparam logic signed [36:0] SAT_HI = CMAX - 37'sd1;
    localparam logic signed [36:0] SAT_LO = -CMAX;

    logic [3:0] state_reg;
    job_t job_reg;
    logic [1:0] which_reg;      // 0: |Q-R|, 1: |Q-P|, 2: |R-P|; then 0: x, 1: y
    logic [DW-1:0] ma_reg, mb_reg;
    logic [DW-1:0] nx_reg, ny_reg;
    logic sx_reg, sy_reg;
    logic [SW-1:0] s_reg, rem_reg;
    logic [RW-1:0] root_reg, n_reg, a_reg;
    logic [6:0] bit_reg;
    logic [KW-1:0] k_reg;
    logic [NUMW-1:0] num_reg;
    logic [QW-1:0] q_reg;
    logic signed [36:0] ox_reg, oy_reg;
    logic [66:0] sq_a_reg, sq_b_reg;
    logic out_full_reg;

    logic signed [32:0] dx, dy;
    logic [DW-1:0] mx, my;
    logic [DW-1:0] mcomp;
    logic [KW+16:0] part;
    logic [RW-1:0] cand;
    logic [71:0] cand_sq;
    logic [RW+16:0] rem_try;
    logic [RW+15:0] divisor;
    logic signed [36:0] pxw, pyw;
    logic out_load;

    // Clamp a quotient to a signed offset; anything past the range saturates anyway.
    function automatic logic signed [36:0] clip(input logic [QW-1:0] q, input logic neg);
        logic [35:0] m;
        m = (q > 64'h7_FFFF_FFFF) ? 36'h7_FFFF_FFFF : 36'(q);
        return neg ? -37'(m) : 37'(m);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [36:0] v);
        if (v > SAT_HI) return COORD_BITS'(SAT_HI);
        else if (v < SAT_LO) return COORD_BITS'(SAT_LO);
        else return COORD_BITS'(v);
    endfunction

    // Component pair of the distance being measured.
    always_comb begin
        case (which_reg)
            2'd1: begin
                dx = 33'(job_reg.qx) - 33'(job_reg.px);
                dy = 33'(job_reg.qy) - 33'(job_reg.py);
            end
            2'd2: begin
                dx = 33'(job_reg.rx) - 33'(job_reg.px);
                dy = 33'(job_reg.ry) - 33'(job_reg.py);
            end
            default: begin
                dx = 33'(job_reg.qx) - 33'(job_reg.rx);
                dy = 33'(job_reg.qy) - 33'(job_reg.ry);
            end
        endcase
        mx = dx[32] ? DW'(-dx) : DW'(dx);
        my = dy[32] ? DW'(-dy) : DW'(dy);
    end

    // Square root step: try one more bit, compare its square against the sum.
    assign cand = root_reg | (RW'(1) << bit_reg[5:0]);
    assign cand_sq = 72'(cand) * 72'(cand);
    assign divisor = {n_reg, 16'd0};
    assign rem_try = {rem_reg[RW+15:0], num_reg[NUMW-1]};
    assign pxw = 37'(job_reg.px);
    assign pyw = 37'(job_reg.py);

    // Tangent component being scaled, multiplied by k in two 17-bit halves.
    assign mcomp = which_reg[0] ? ny_reg : nx_reg;
    assign part = (KW+17)'(k_reg) * (KW+17)'((state_reg == S_MUL) ? mcomp[DW-1:17]
                                                                   : mcomp[16:0]);

    assign j_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && (!out_full_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_full_reg <= 1'b0;
            which_reg <= 2'd0;
        end else begin
            if (out_load) out_full_reg <= 1'b1;
            else if (m_valid && m_ready) out_full_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (j_valid) begin
                    job_reg <= j_job;
                    which_reg <= 2'd0;
                    a_reg <= '0;
                    ox_reg <= '0;
                    oy_reg <= '0;
                    state_reg <= j_job.zero ? S_OUT : S_SQ;
                end
                S_SQ: begin
                    ma_reg <= mx;
                    mb_reg <= my;
                    // Keep the tangent difference for the scaling phase.
                    if (which_reg == 2'd0) begin
                        nx_reg <= mx;
                        ny_reg <= my;
                        sx_reg <= dx[32];
                        sy_reg <= dy[32];
                    end
                    state_reg <= S_SQ2;
                end
                S_SQ2: begin
                    sq_a_reg <= 67'(ma_reg) * 67'(ma_reg);
                    sq_b_reg <= 67'(mb_reg) * 67'(mb_reg);
                    state_reg <= S_K;
                    bit_reg <= 7'd34;
                    root_reg <= '0;
                end
                S_K: begin
                    s_reg <= SW'(sq_a_reg) + SW'(sq_b_reg);
                    state_reg <= S_ROOT;
                end
                S_ROOT: begin
                    if (cand_sq <= 72'(s_reg)) root_reg <= cand;
                    if (bit_reg == 7'd0) state_reg <= S_NEXT;
                    else bit_reg <= bit_reg - 7'd1;
                end
                S_NEXT: begin
                    if (which_reg == 2'd0) begin
                        n_reg <= root_reg;
                        if (root_reg == '0) state_reg <= S_OUT;
                        else begin
                            which_reg <= 2'd1;
                            state_reg <= S_SQ;
                        end
                    end else if (which_reg == 2'd1) begin
                        a_reg <= root_reg;
                        which_reg <= 2'd2;
                        state_reg <= S_SQ;
                    end else begin
                        k_reg <= KW'(tension) * (KW'(a_reg) + KW'(root_reg));
                        which_reg <= 2'd0;
                        state_reg <= S_NUM;
                    end
                end
                S_NUM: begin
                    // Low half of k * |d|, plus divisor / 2 for rounding.
                    num_reg <= NUMW'(part) + NUMW'(divisor >> 1);
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    // High half of k * |d|, then restoring division.
                    num_reg <= num_reg + (NUMW'(part) << 17);
                    rem_reg <= '0;
                    q_reg <= '0;
                    bit_reg <= 7'(NUMW - 1);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (rem_try >= (RW + 17)'(divisor)) begin
                        rem_reg <= SW'(rem_try - (RW + 17)'(divisor));
                        q_reg <= {q_reg[QW-2:0], 1'b1};
                    end else begin
                        rem_reg <= SW'(rem_try);
                        q_reg <= {q_reg[QW-2:0], 1'b0};
                    end
                    num_reg <= {num_reg[NUMW-2:0], 1'b0};
                    if (bit_reg != 7'd0) bit_reg <= bit_reg - 7'd1;
                    else if (which_reg == 2'd0) begin
                        which_reg <= 2'd1;
                        state_reg <= S_NUM;
                    end else state_reg <= S_OUT;
                    if (bit_reg == 7'd0 && which_reg == 2'd0) begin
                        ox_reg <= clip({q_reg[QW-2:0], rem_try >= (RW + 17)'(divisor)},
                                       sx_reg);
                    end
                    if (bit_reg == 7'd0 && which_reg == 2'd1) begin
                        oy_reg <= clip({q_reg[QW-2:0], rem_try >= (RW + 17)'(divisor)},
                                       sy_reg);
                    end
                end
                S_OUT: if (out_load) begin
                    m_point_index <= INDEX_BITS'(job_reg.idx);
                    m_last_result <= job_reg.last;
                    if (job_reg.zero) begin
                        m_ctrl_a_x <= '0; m_ctrl_a_y <= '0;
                        m_ctrl_b_x <= '0; m_ctrl_b_y <= '0;
                    end else begin
                        m_ctrl_a_x <= sat(pxw + ox_reg);
                        m_ctrl_a_y <= sat(pyw + oy_reg);
                        m_ctrl_b_x <= sat(pxw - ox_reg);
                        m_ctrl_b_y <= sat(pyw - oy_reg);
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = out_full_reg;

    // The output register is never overwritten while a result waits.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !j_ready) else $error("job taken while busy");
    a_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROOT) |-> bit_reg <= 7'd34) else $error("root step out of range");

endmodule

FILE: hdl/spline_tangent_smoother.sv
// Top level of the spline tangent smoother: config registers, front, queue, back.
// Depends on sts_pkg, sts_front, sts_queue, sts_back.
//
//  channel  direction  signals
//  s_       in         s_valid s_ready s_point_x s_point_y s_last_point
//  m_       out        m_valid m_ready m_point_index m_ctrl_a/b_x/y m_last_result
//  cfg      in         cfg_we cfg_index cfg_data
//
// Back end steps per result: accept, three distances (35-step square root each),
// two offsets (two-step multiply, 88-step restoring division each), output load.
// Coinciding neighbors go to the output after the first distance, an open end
// point right after accept. A point causes zero to three results; the front end
// issues them into a two-entry queue and waits until all are queued. Reset is
// synchronous and clears the list position; output stalls hold the back end.
module spline_tangent_smoother import sts_pkg::*; #(
    parameter int INDEX_BITS = 16,
    parameter int COORD_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [15:0]                  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_point_x,
    input  logic signed [COORD_BITS-1:0] s_point_y,
    input  logic                         s_last_point,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [INDEX_BITS-1:0]        m_point_index,
    output logic signed [COORD_BITS-1:0] m_ctrl_a_x,
    output logic signed [COORD_BITS-1:0] m_ctrl_a_y,
    output logic signed [COORD_BITS-1:0] m_ctrl_b_x,
    output logic signed [COORD_BITS-1:0] m_ctrl_b_y,
    output logic                         m_last_result
);

    logic closed_reg;
    logic [15:0] tension_reg;
    logic f_valid, f_ready, b_valid, b_ready;
    job_t f_job, b_job;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            closed_reg <= 1'b0;
            tension_reg <= TENSION_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CLOSED_LOOP: closed_reg <= cfg_data[0];
                REG_TENSION: tension_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sts_front #(.INDEX_BITS(INDEX_BITS), .COORD_BITS(COORD_BITS)) u_front (
        .aclk, .aresetn, .closed_loop(closed_reg), .s_valid, .s_ready,
        .s_point_x, .s_point_y, .s_last_point,
        .j_valid(f_valid), .j_ready(f_ready), .j_job(f_job)
    );

    sts_queue u_queue (
        .aclk, .aresetn, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
        .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
    );

    sts_back #(.INDEX_BITS(INDEX_BITS), .COORD_BITS(COORD_BITS)) u_back (
        .aclk, .aresetn, .tension(tension_reg),
        .j_valid(b_valid), .j_ready(b_ready), .j_job(b_job),
        .m_valid, .m_ready, .m_point_index, .m_ctrl_a_x, .m_ctrl_a_y,
        .m_ctrl_b_x, .m_ctrl_b_y, .m_last_result
    );

endmodule
